// ===== hw/rtl/se2ft_pkg.sv =====
package se2ft_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_X       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_Y       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEADING = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME    = 4'd3;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_POSE  = 1'b1;

	// first products 32x16, second products 35x16
	localparam int unsigned P1_W  = 48;
	localparam int unsigned M_W   = 35;
	localparam int unsigned P2_W  = 51;
	localparam int unsigned RND_W = 56;
	localparam int unsigned RES_W = 41;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [15:0] heading;
		logic        [47:0] stamp;
		logic signed [15:0] sin_v;
		logic signed [15:0] cos_v;
	} frame_cfg_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [15:0] child_heading;
		logic               has_cov;
		logic signed [31:0] cov_xx;
		logic signed [31:0] cov_xy;
		logic signed [31:0] cov_yy;
		logic        [47:0] time_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_heading;
		logic signed [31:0] out_cov_xx;
		logic signed [31:0] out_cov_xy;
		logic signed [31:0] out_cov_yy;
		logic        [47:0] out_time;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               clip;
	} sat_t;

	// sin(pi/2 * t), t and result in Q30
	function automatic logic [63:0] quarter_sine(input logic [63:0] t);
		logic [63:0] t2;
		logic [63:0] p;
		t2 = (t * t) >> 30;
		p = 64'd3864;
		p = 64'd172272 - ((p * t2) >> 30);
		p = 64'd5026995 - ((p * t2) >> 30);
		p = 64'd85569306 - ((p * t2) >> 30);
		p = 64'd693598668 - ((p * t2) >> 30);
		p = 64'd1686629713 - ((p * t2) >> 30);
		return (p * t) >> 30;
	endfunction

	// floor((v + 2^14) / 2^15)
	function automatic logic signed [RES_W-1:0] round15(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] t;
		t = v + RND_W'(16384);
		return RES_W'(t >>> 15);
	endfunction

	function automatic sat_t sat32(input logic signed [RES_W-1:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.val = 32'(v);
		if (v > RES_W'(64'sd2147483647)) begin
			r.clip = 1'b1;
			r.val = 32'sh7fffffff;
		end else if (v < -RES_W'(64'sd2147483648)) begin
			r.clip = 1'b1;
			r.val = 32'sh80000000;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/se2ft_sine_rom.sv =====
module se2ft_sine_rom #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic        [15:0] heading,
	output logic signed [15:0] sin_v,
	output logic signed [15:0] cos_v
);
	import se2ft_pkg::*;

	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned PROD_W = 16 + IDX_W;

	logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_tab
		localparam int unsigned Q = (i * 4) / SINE_TABLE_DEPTH;
		localparam int unsigned R0 = i * 4 - Q * SINE_TABLE_DEPTH;
		localparam int unsigned R = (Q % 2 == 1) ? SINE_TABLE_DEPTH - R0 : R0;
		localparam longint unsigned T = (64'(R) << 30) / SINE_TABLE_DEPTH;
		localparam longint unsigned V0 = (quarter_sine(T) + 64'd16384) >> 15;
		localparam longint unsigned V = (V0 > 64'd32767) ? 64'd32767 : V0;
		localparam logic signed [15:0] E = (Q >= 2) ? -16'(V) : 16'(V);
		assign sine_rom[i] = E;
	end

	logic [15:0]        cos_angle;
	logic [PROD_W-1:0]  sin_prod;
	logic [PROD_W-1:0]  cos_prod;
	logic [IDX_W-1:0]   sin_idx;
	logic [IDX_W-1:0]   cos_idx;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;

	// quarter turn ahead gives cosine
	assign cos_angle = heading + 16'd16384;
	assign sin_prod = PROD_W'(heading) * PROD_W'(SINE_TABLE_DEPTH);
	assign cos_prod = PROD_W'(cos_angle) * PROD_W'(SINE_TABLE_DEPTH);
	assign sin_idx = sin_prod[PROD_W-1:16];
	assign cos_idx = cos_prod[PROD_W-1:16];

	always_ff @(posedge clk) begin
		sin_q <= sine_rom[sin_idx];
		cos_q <= sine_rom[cos_idx];
	end

	assign sin_v = sin_q;
	assign cos_v = cos_q;

endmodule

// ===== hw/rtl/se2ft_cfg_regs.sv =====
module se2ft_cfg_regs #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [se2ft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [se2ft_pkg::CFG_DATA_W-1:0] cfg_data,
	output se2ft_pkg::frame_cfg_t            frame
);
	import se2ft_pkg::*;

	logic signed [31:0] frame_x_q;
	logic signed [31:0] frame_y_q;
	logic        [15:0] frame_heading_q;
	logic        [47:0] frame_time_q;
	logic signed [15:0] sin_v;
	logic signed [15:0] cos_v;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_x_q <= '0;
			frame_y_q <= '0;
			frame_heading_q <= '0;
			frame_time_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_X:       frame_x_q <= cfg_data[31:0];
				REG_FRAME_Y:       frame_y_q <= cfg_data[31:0];
				REG_FRAME_HEADING: frame_heading_q <= cfg_data[15:0];
				REG_FRAME_TIME:    frame_time_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	se2ft_sine_rom #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk    (clk),
		.heading(frame_heading_q),
		.sin_v  (sin_v),
		.cos_v  (cos_v)
	);

	always_comb begin
		frame.x = frame_x_q;
		frame.y = frame_y_q;
		frame.heading = frame_heading_q;
		frame.stamp = frame_time_q;
		frame.sin_v = sin_v;
		frame.cos_v = cos_v;
	end

endmodule

// ===== hw/rtl/se2ft_datapath.sv =====
module se2ft_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  se2ft_pkg::frame_cfg_t frame,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  se2ft_pkg::in_item_t   in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output se2ft_pkg::out_item_t  out_item
);
	import se2ft_pkg::*;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic signed [15:0] s;
	logic signed [15:0] c;
	logic signed [31:0] fx;
	logic signed [31:0] fy;

	// stage 1: captured transaction
	logic               kind_s1, cov_s1;
	logic signed [31:0] px_s1, py_s1, a_s1, b_s1, d_s1;
	logic        [15:0] ch_s1;
	logic        [47:0] tin_s1;

	// stage 2: first rotation products
	logic               kind_s2, cov_s2;
	logic signed [P1_W-1:0] pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic signed [P1_W-1:0] ca_s2, sb_s2, cb_s2, sd_s2, sa_s2, cd_s2;
	logic        [15:0] heading_s2;
	logic        [47:0] time_s2;

	// stage 3: rounded sums, translated position
	logic               kind_s3, cov_s3;
	logic signed [RES_W-1:0] x_s3, y_s3;
	logic signed [M_W-1:0] m00_s3, m01_s3, m10_s3, m11_s3;
	logic        [15:0] heading_s3;
	logic        [47:0] time_s3;

	// stage 4: clamped position, second products
	logic               kind_s4, cov_s4, clip_s4;
	logic signed [31:0] x_s4, y_s4;
	logic signed [P2_W-1:0] q00c_s4, q01s_s4, q00s_s4, q01c_s4, q10s_s4, q11c_s4;
	logic        [15:0] heading_s4;
	logic        [47:0] time_s4;

	// stage 5: output register
	logic               kind_s5, cov_s5;
	out_item_t          res_s5;

	sat_t sx, sy, sxx, sxy, syy;

	assign s = frame.sin_v;
	assign c = frame.cos_v;
	assign fx = frame.x;
	assign fy = frame.y;

	// whole pipe holds while the result register is blocked
	assign en = !(valid_s5 && out_stall);
	assign in_stall = !en;
	assign out_valid = valid_s5;
	assign out_item = res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_comb begin
		sx = sat32(x_s3);
		sy = sat32(y_s3);
		sxx = sat32(round15(RND_W'(q00c_s4) - RND_W'(q01s_s4)));
		sxy = sat32(round15(RND_W'(q00s_s4) + RND_W'(q01c_s4)));
		syy = sat32(round15(RND_W'(q10s_s4) + RND_W'(q11c_s4)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_item.kind;
			cov_s1 <= in_item.has_cov && (in_item.kind == KIND_POINT);
			px_s1 <= in_item.point_x;
			py_s1 <= in_item.point_y;
			ch_s1 <= in_item.child_heading;
			a_s1 <= in_item.cov_xx;
			b_s1 <= in_item.cov_xy;
			d_s1 <= in_item.cov_yy;
			tin_s1 <= in_item.time_in;

			kind_s2 <= kind_s1;
			cov_s2 <= cov_s1;
			pcx_s2 <= px_s1 * c;
			psy_s2 <= py_s1 * s;
			psx_s2 <= px_s1 * s;
			pcy_s2 <= py_s1 * c;
			ca_s2 <= a_s1 * c;
			sb_s2 <= b_s1 * s;
			cb_s2 <= b_s1 * c;
			sd_s2 <= d_s1 * s;
			sa_s2 <= a_s1 * s;
			cd_s2 <= d_s1 * c;
			if (kind_s1 == KIND_POSE) begin
				heading_s2 <= frame.heading + ch_s1;
				time_s2 <= (frame.stamp > tin_s1) ? frame.stamp : tin_s1;
			end else begin
				heading_s2 <= '0;
				time_s2 <= tin_s1;
			end

			kind_s3 <= kind_s2;
			cov_s3 <= cov_s2;
			x_s3 <= round15(RND_W'(pcx_s2) - RND_W'(psy_s2)) + RES_W'(fx);
			y_s3 <= round15(RND_W'(psx_s2) + RND_W'(pcy_s2)) + RES_W'(fy);
			m00_s3 <= M_W'(round15(RND_W'(ca_s2) - RND_W'(sb_s2)));
			m01_s3 <= M_W'(round15(RND_W'(cb_s2) - RND_W'(sd_s2)));
			m10_s3 <= M_W'(round15(RND_W'(sa_s2) + RND_W'(cb_s2)));
			m11_s3 <= M_W'(round15(RND_W'(sb_s2) + RND_W'(cd_s2)));
			heading_s3 <= heading_s2;
			time_s3 <= time_s2;

			kind_s4 <= kind_s3;
			cov_s4 <= cov_s3;
			x_s4 <= sx.val;
			y_s4 <= sy.val;
			clip_s4 <= sx.clip || sy.clip;
			q00c_s4 <= m00_s3 * c;
			q01s_s4 <= m01_s3 * s;
			q00s_s4 <= m00_s3 * s;
			q01c_s4 <= m01_s3 * c;
			q10s_s4 <= m10_s3 * s;
			q11c_s4 <= m11_s3 * c;
			heading_s4 <= heading_s3;
			time_s4 <= time_s3;

			kind_s5 <= kind_s4;
			cov_s5 <= cov_s4;
			res_s5.out_x <= x_s4;
			res_s5.out_y <= y_s4;
			res_s5.out_heading <= heading_s4;
			res_s5.out_time <= time_s4;
			if (cov_s4) begin
				res_s5.out_cov_xx <= sxx.val;
				res_s5.out_cov_xy <= sxy.val;
				res_s5.out_cov_yy <= syy.val;
				res_s5.saturated <= clip_s4 || sxx.clip || sxy.clip || syy.clip;
			end else begin
				res_s5.out_cov_xx <= '0;
				res_s5.out_cov_xy <= '0;
				res_s5.out_cov_yy <= '0;
				res_s5.saturated <= clip_s4;
			end
		end
	end

	a_point_heading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && (kind_s5 == KIND_POINT) |-> res_s5.out_heading == '0)
		else $error("point transaction with nonzero heading");

	a_no_cov_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !cov_s5 |->
		res_s5.out_cov_xx == '0 && res_s5.out_cov_xy == '0 && res_s5.out_cov_yy == '0)
		else $error("covariance output without covariance input");

	a_pose_no_cov: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && (kind_s4 == KIND_POSE) |-> !cov_s4)
		else $error("pose transaction carries covariance");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en && valid_s4 |=> valid_s4 && valid_s5)
		else $error("pipeline lost a transaction during stall");

endmodule

// ===== hw/rtl/se2_frame_transform_top.sv =====
// SE(2) frame transform: applies the configured frame pose (frame_x, frame_y,
// frame_heading, frame_time) to each transaction. A point (kind 0) is rotated
// and translated into the base frame, with its covariance rotated as R*C*R^T
// when has_cov is set; a pose (kind 1) is composed with the frame, headings
// adding modulo a full turn and out_time taking the later stamp. Positions and
// covariances are signed Q16.16 and clamp to the 32-bit range, flagged on
// saturated. One transaction is taken every cycle unless a stalled result holds
// the pipe; it passes through the input capture, first multiply, rounding, second
// multiply and output registers. Sine and cosine come from a registered table of
// SINE_TABLE_DEPTH entries looked up from the registered heading, so the first
// transaction may follow a configuration write on the next cycle. Configuration
// writes are always ready and must be made while no transaction is in flight.
module se2_frame_transform_top #(
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [se2ft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [se2ft_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic signed [31:0]               point_x,
	input  logic signed [31:0]               point_y,
	input  logic signed [15:0]               child_heading,
	input  logic                             has_cov,
	input  logic signed [31:0]               cov_xx,
	input  logic signed [31:0]               cov_xy,
	input  logic signed [31:0]               cov_yy,
	input  logic [47:0]                      time_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               out_x,
	output logic signed [31:0]               out_y,
	output logic signed [15:0]               out_heading,
	output logic signed [31:0]               out_cov_xx,
	output logic signed [31:0]               out_cov_xy,
	output logic signed [31:0]               out_cov_yy,
	output logic [47:0]                      out_time,
	output logic                             saturated
);
	import se2ft_pkg::*;

	frame_cfg_t frame;
	in_item_t   in_item;
	out_item_t  out_item;

	se2ft_cfg_regs #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.frame    (frame)
	);

	always_comb begin
		in_item.kind = kind;
		in_item.point_x = point_x;
		in_item.point_y = point_y;
		in_item.child_heading = child_heading;
		in_item.has_cov = has_cov;
		in_item.cov_xx = cov_xx;
		in_item.cov_xy = cov_xy;
		in_item.cov_yy = cov_yy;
		in_item.time_in = time_in;
	end

	se2ft_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	assign out_x = out_item.out_x;
	assign out_y = out_item.out_y;
	assign out_heading = out_item.out_heading;
	assign out_cov_xx = out_item.out_cov_xx;
	assign out_cov_xy = out_item.out_cov_xy;
	assign out_cov_yy = out_item.out_cov_yy;
	assign out_time = out_item.out_time;
	assign saturated = out_item.saturated;

endmodule

// ===== tb/tb_se2_frame_transform_top.sv =====
module tb_se2_frame_transform_top;
	import se2ft_pkg::*;

	localparam int unsigned SINE_DEPTH = 256;
	localparam int unsigned RESULT_LATENCY = 5;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	// odd polynomial for a quarter sine wave, Q30, highest order last
	localparam longint unsigned SINE_POLY [6] = '{
		64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t drive_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t seen;

	// frame pose as the block should hold it
	logic signed [31:0] frame_x_q = '0;
	logic signed [31:0] frame_y_q = '0;
	logic [15:0] frame_heading_q = '0;
	logic [47:0] frame_stamp_q = '0;

	in_item_t pending_items[$];
	out_item_t expected_results[$];

	bit item_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	bit sender_gaps = 1'b0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_count = 0;

	int errors = 0;
	int results_checked = 0;
	int pose_count = 0;
	int cov_count = 0;
	int clamp_count = 0;
	int in_stall_cycles = 0;
	int cfg_writes = 0;

	se2_frame_transform_top #(.SINE_TABLE_DEPTH(SINE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(drive_item.kind),
		.point_x(drive_item.point_x),
		.point_y(drive_item.point_y),
		.child_heading(drive_item.child_heading),
		.has_cov(drive_item.has_cov),
		.cov_xx(drive_item.cov_xx),
		.cov_xy(drive_item.cov_xy),
		.cov_yy(drive_item.cov_yy),
		.time_in(drive_item.time_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_x(seen.out_x),
		.out_y(seen.out_y),
		.out_heading(seen.out_heading),
		.out_cov_xx(seen.out_cov_xx),
		.out_cov_xy(seen.out_cov_xy),
		.out_cov_yy(seen.out_cov_yy),
		.out_time(seen.out_time),
		.saturated(seen.saturated)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("se2_frame_transform_top test failed");
		$finish;
	end

	// Q1.15 table lookup, one of SINE_DEPTH entries over a full turn
	function automatic longint table_sine(input logic [15:0] angle);
		longint unsigned idx, quad, r, t, t2, p, v;
		idx = ((64'(angle) * SINE_DEPTH) >> 16) % SINE_DEPTH;
		quad = (idx * 4) / SINE_DEPTH;
		r = idx * 4 - quad * SINE_DEPTH;
		if (quad[0]) begin
			r = SINE_DEPTH - r;
		end
		t = (r << 30) / SINE_DEPTH;
		t2 = (t * t) >> 30;
		p = SINE_POLY[5];
		for (int k = 4; k >= 0; k--) begin
			p = SINE_POLY[k] - ((p * t2) >> 30);
		end
		v = (((p * t) >> 30) + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return quad[1] ? -longint'(v) : longint'(v);
	endfunction

	// divide by 2^15, ties toward plus infinity
	function automatic longint scale_down(input longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	// bit 32 flags a clamp
	function automatic logic [32:0] clamp32(input longint v);
		if (v > Q_MAX) begin
			return {1'b1, 32'h7FFFFFFF};
		end
		if (v < Q_MIN) begin
			return {1'b1, 32'h80000000};
		end
		return {1'b0, v[31:0]};
	endfunction

	function automatic out_item_t transform_item(input in_item_t it);
		out_item_t r;
		longint s, c, px, py, a, b, d, m00, m01, m10, m11;
		logic [32:0] cx, cy, k0, k1, k2;
		s = table_sine(frame_heading_q);
		c = table_sine(frame_heading_q + 16'h4000);
		px = $signed(it.point_x);
		py = $signed(it.point_y);
		a = $signed(it.cov_xx);
		b = $signed(it.cov_xy);
		d = $signed(it.cov_yy);
		cx = clamp32(scale_down(c * px - s * py) + longint'($signed(frame_x_q)));
		cy = clamp32(scale_down(s * px + c * py) + longint'($signed(frame_y_q)));
		k0 = '0;
		k1 = '0;
		k2 = '0;
		r = '0;
		if (it.kind == KIND_POINT) begin
			r.out_time = it.time_in;
			if (it.has_cov) begin
				// R*C first, kept wide, then times R transposed
				m00 = scale_down(c * a - s * b);
				m01 = scale_down(c * b - s * d);
				m10 = scale_down(s * a + c * b);
				m11 = scale_down(s * b + c * d);
				k0 = clamp32(scale_down(m00 * c - m01 * s));
				k1 = clamp32(scale_down(m00 * s + m01 * c));
				k2 = clamp32(scale_down(m10 * s + m11 * c));
			end
		end else begin
			r.out_heading = frame_heading_q + it.child_heading;
			r.out_time = (frame_stamp_q > it.time_in) ? frame_stamp_q : it.time_in;
		end
		r.out_x = cx[31:0];
		r.out_y = cy[31:0];
		r.out_cov_xx = k0[31:0];
		r.out_cov_xy = k1[31:0];
		r.out_cov_yy = k2[31:0];
		r.saturated = cx[32] | cy[32] | k0[32] | k1[32] | k2[32];
		return r;
	endfunction

	function automatic logic [31:0] pick_q16();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return r;
			default: return {{11{r[20]}}, r[20:0]};
		endcase
	endfunction

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] pick_stamp();
		case ($urandom_range(5))
			0: return 48'h0;
			1: return 48'hFFFFFFFFFFFF;
			2: return 48'($urandom_range(1000));
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.kind = 1'($urandom_range(1));
		it.point_x = pick_q16();
		it.point_y = pick_q16();
		it.child_heading = pick_angle();
		it.has_cov = 1'($urandom_range(1));
		it.cov_xx = pick_q16();
		it.cov_xy = pick_q16();
		it.cov_yy = pick_q16();
		it.time_in = pick_stamp();
		return it;
	endfunction

	task automatic queue_item(input logic k, input logic [31:0] px, input logic [31:0] py,
			input logic [15:0] ch, input logic hc, input logic [31:0] cxx,
			input logic [31:0] cxy, input logic [31:0] cyy, input logic [47:0] stamp);
		in_item_t it;
		it.kind = k;
		it.point_x = px;
		it.point_y = py;
		it.child_heading = ch;
		it.has_cov = hc;
		it.cov_xx = cxx;
		it.cov_xy = cxy;
		it.cov_yy = cyy;
		it.time_in = stamp;
		pending_items.push_back(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FRAME_X: frame_x_q = data[31:0];
			REG_FRAME_Y: frame_y_q = data[31:0];
			REG_FRAME_HEADING: frame_heading_q = data[15:0];
			REG_FRAME_TIME: frame_stamp_q = data[47:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain everything before touching the frame registers
	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (RESULT_LATENCY + 3) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// sender: bursts of items, with random gaps when sender_gaps is set, payload held while stalled
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !item_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				drive_item <= pending_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = sender_gaps ? $urandom_range(0, 6) : 0;
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_count = 80;
			out_stall <= 1'b1;
		end else if (hold_count > 0) begin
			hold_count--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		item_taken = arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && in_stall) begin
			in_stall_cycles++;
		end
		if (item_taken) begin
			want = transform_item(drive_item);
			expected_results.push_back(want);
			if (drive_item.kind == KIND_POSE) begin
				pose_count++;
			end else if (drive_item.has_cov) begin
				cov_count++;
			end
			if (want.saturated) begin
				clamp_count++;
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result transaction with nothing expected, got %h", $time, seen);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("out_x", want.out_x, seen.out_x);
				check_field("out_y", want.out_y, seen.out_y);
				check_field("out_heading", want.out_heading, seen.out_heading);
				check_field("out_cov_xx", want.out_cov_xx, seen.out_cov_xx);
				check_field("out_cov_xy", want.out_cov_xy, seen.out_cov_xy);
				check_field("out_cov_yy", want.out_cov_yy, seen.out_cov_yy);
				check_field("out_time", want.out_time, seen.out_time);
				check_field("saturated", want.saturated, seen.saturated);
				results_checked++;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset frame: identity apart from the table's 32767 cosine
		sender_gaps = 1'b1;
		stall_pct = 20;
		queue_item(KIND_POINT, 32'h0, 32'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 48'h0);
		queue_item(KIND_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b1,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'hFFFFFFFFFFFF);
		queue_item(KIND_POINT, 32'h80000000, 32'h80000000, 16'h8000, 1'b1,
			32'h80000000, 32'h80000000, 32'h80000000, 48'h123456789ABC);
		queue_item(KIND_POSE, 32'h80000000, 32'h00010000, 16'h7FFF, 1'b1,
			32'h1, 32'h2, 32'h3, 48'h5);
		queue_item(KIND_POSE, 32'hFFFF0000, 32'h7FFFFFFF, 16'h8000, 1'b0,
			32'h0, 32'h0, 32'h0, 48'h0);
		// covariance fields present but not flagged
		queue_item(KIND_POINT, 32'h00018000, 32'hFFFE8000, 16'h1234, 1'b0,
			32'h7FFFFFFF, 32'h80000000, 32'h55555555, 48'hAAAAAAAAAAAA);

		wait_idle();
		write_reg(REG_FRAME_X, 48'h0000_7FFFFFFF);
		write_reg(REG_FRAME_Y, 48'hFFFF_80000000);
		write_reg(REG_FRAME_HEADING, 48'h0000_00002000);
		write_reg(REG_FRAME_TIME, 48'hFFFFFFFFFFFF);
		// writes past the last register must be dropped
		write_reg(CFG_IDX_W'(REG_FRAME_TIME + 1), 48'h5A5A_5A5A5A5A);
		write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 48'hFFFFFFFFFFFF);
		queue_item(KIND_POINT, 32'h7FFFFFFF, 32'h0, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 48'h1);
		queue_item(KIND_POINT, 32'h0, 32'h80000000, 16'h0, 1'b0, 32'h0, 32'h0, 32'h0, 48'h2);
		queue_item(KIND_POINT, 32'h0, 32'h0, 16'h0, 1'b1,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'h3);
		// heading sum wraps past the positive extreme
		queue_item(KIND_POSE, 32'h00010000, 32'h00010000, 16'h7FFF, 1'b0,
			32'h0, 32'h0, 32'h0, 48'h0);
		queue_item(KIND_POSE, 32'hFFFFFFFF, 32'h1, 16'hE000, 1'b1,
			32'h7FFFFFFF, 32'h0, 32'h0, 48'hFFFFFFFFFFFF);
		queue_item(KIND_POINT, 32'h1, 32'hFFFFFFFF, 16'h0, 1'b1,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 48'h0);

		wait_idle();
		write_reg(REG_FRAME_X, 48'h0000_80000000);
		write_reg(REG_FRAME_Y, 48'h0000_7FFFFFFF);
		write_reg(REG_FRAME_HEADING, 48'hFFFF_FFFF8000);
		write_reg(REG_FRAME_TIME, 48'h1);
		queue_item(KIND_POINT, 32'h80000000, 32'h80000000, 16'h0, 1'b0,
			32'h0, 32'h0, 32'h0, 48'h7);
		queue_item(KIND_POSE, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 1'b0,
			32'h0, 32'h0, 32'h0, 48'h0);
		queue_item(KIND_POINT, 32'h00020000, 32'hFFFE0000, 16'h0, 1'b1,
			32'h00040000, 32'hFFFF0000, 32'h00090000, 48'h2);
		queue_item(KIND_POSE, 32'h0, 32'h0, 16'h0001, 1'b0, 32'h0, 32'h0, 32'h0, 48'h2);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_reg(REG_FRAME_X, {16'($urandom), pick_q16()});
			write_reg(REG_FRAME_Y, {16'($urandom), pick_q16()});
			write_reg(REG_FRAME_HEADING,
				{32'($urandom), (ph == 0) ? 16'h7FFF : pick_angle()});
			write_reg(REG_FRAME_TIME, pick_stamp());
			write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_TIME + 1, (1 << CFG_IDX_W) - 1)),
				48'({$urandom, $urandom}));
			sender_gaps = ph[0];
			case (ph)
				2: stall_pct = 35;
				3: stall_pct = 60;
				5: stall_pct = 20;
				default: stall_pct = 0;
			endcase
			repeat (75) pending_items.push_back(random_item());
			// sender keeps offering while the output is held off
			if (ph == 4) begin
				hold_requests++;
			end
		end

		wait_idle();
		repeat (RESULT_LATENCY * 2) @(posedge clk);
		$display("%0d transactions checked: %0d poses, %0d points with covariance, %0d clamped",
			results_checked, pose_count, cov_count, clamp_count);
		$display("%0d register writes; input held back on %0d cycles", cfg_writes, in_stall_cycles);
		if (errors == 0) begin
			$display("se2_frame_transform_top test passed");
		end else begin
			$display("se2_frame_transform_top test failed");
		end
		$finish;
	end

endmodule
